// File: hdl/ccd_pkg.sv
// Shared types, constants and helper functions of the character-cell draw engine.
`timescale 1ns / 1ps
package ccd_pkg;

	// Screen geometry.
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;

	// Field widths.
	localparam int COORD_W = 10;
	localparam int POS_W   = 8;
	localparam int CHAR_W  = 8;

	// Characters written by the draw commands.
	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
	localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
	localparam logic [CHAR_W-1:0] CH_VEE   = 8'h76;
	localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	// Command codes.
	typedef enum logic [2:0] {
		MODE_PIXEL  = 3'd0,
		MODE_HLINE  = 3'd1,
		MODE_VLINE  = 3'd2,
		MODE_HARROW = 3'd3,
		MODE_VARROW = 3'd4,
		MODE_RECT   = 3'd5,
		MODE_READ   = 3'd6,
		MODE_CLEAR  = 3'd7
	} mode_t;

	// One draw request.
	typedef struct packed {
		logic [2:0]                mode;
		logic signed [COORD_W-1:0] x_a;
		logic signed [COORD_W-1:0] y_a;
		logic signed [COORD_W-1:0] x_b;
		logic signed [COORD_W-1:0] y_b;
		logic [CHAR_W-1:0]         fill_char;
	} cmd_t;

	// One result.
	typedef struct packed {
		logic [CHAR_W-1:0] cell_char;
		logic              on_screen;
	} result_t;

	// Access to the cell store.
	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [CHAR_W-1:0] wdata;
	} mem_req_t;

	// True when a point lies on the screen.
	function automatic logic on_scr(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y);
		return !x[COORD_W-1] && !y[COORD_W-1] &&
			($unsigned(x) < COORD_W'(COLUMNS)) && ($unsigned(y) < COORD_W'(ROWS));
	endfunction

	// Linear cell address of an on-screen point.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y);
		return ADDR_W'(32'(y) * 32'(COLUMNS) + 32'(x));
	endfunction

endpackage

// File: hdl/ccd_if.sv
// Request and result channel interfaces of the character-cell draw engine.
`timescale 1ns / 1ps
interface ccd_cmd_if;
	import ccd_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [2:0]                mode;
	logic signed [COORD_W-1:0] x_a;
	logic signed [COORD_W-1:0] y_a;
	logic signed [COORD_W-1:0] x_b;
	logic signed [COORD_W-1:0] y_b;
	logic [CHAR_W-1:0]         fill_char;

	modport source (output valid, mode, x_a, y_a, x_b, y_b, fill_char, input ready);
	modport sink (input valid, mode, x_a, y_a, x_b, y_b, fill_char, output ready);
endinterface

interface ccd_res_if;
	import ccd_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] cell_char;
	logic              on_screen;

	modport source (output valid, cell_char, on_screen, input ready);
	modport sink (input valid, cell_char, on_screen, output ready);
endinterface

// File: hdl/char_cell_shape_draw_engine.sv
// Top level of the character-cell draw engine: sequencer, cell store and result register.
`timescale 1ns / 1ps
// Character-cell screen of COLUMNS x ROWS cells (80 x 25) held in one single-port synchronous
// memory. Each request returns one result. After reset the block runs a clearing pass that
// writes a space to every cell, COLUMNS*ROWS cells (2000), while cmd.ready stays low.
// Everything goes through the store's one port, one cell per cycle while a walk or a clearing
// pass runs. A pixel writes one cell. A line walks its cells, and an arrow its shaft and then
// its head. A rectangle walks its edges and then its corners. A run is drawn only with both
// ends on screen; one that is not drawn writes no cell. A read reads one cell and a clear-all
// runs a new clearing pass over every cell. A finished result waits in an output register; the
// next request is taken while it waits.
module char_cell_shape_draw_engine import ccd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	ccd_cmd_if.sink  cmd,
	ccd_res_if.source res
);

	cmd_t              cmd_data;
	logic              cmd_ready;
	logic              out_free;
	logic              push;
	result_t           push_data;
	mem_req_t          mem_req;
	logic [CHAR_W-1:0] rdata;
	logic              res_valid_q;
	result_t           res_q;

	// Request payload.
	assign cmd_data.mode      = cmd.mode;
	assign cmd_data.x_a       = cmd.x_a;
	assign cmd_data.y_a       = cmd.y_a;
	assign cmd_data.x_b       = cmd.x_b;
	assign cmd_data.y_b       = cmd.y_b;
	assign cmd_data.fill_char = cmd.fill_char;
	assign cmd.ready          = cmd_ready;

	ccd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_data  (cmd_data),
		.cmd_ready (cmd_ready),
		.out_free  (out_free),
		.push      (push),
		.push_data (push_data),
		.mem_req   (mem_req),
		.rdata     (rdata)
	);

	ccd_cell_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (rdata)
	);

	// Output register: free when empty or being taken.
	assign out_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= push_data;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.cell_char = res_q.cell_char;
	assign res.on_screen = res_q.on_screen;

endmodule

// File: hdl/ccd_cell_store.sv
// Screen cell memory: one write or one read per cycle, registered read data.
`timescale 1ns / 1ps
module ccd_cell_store import ccd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_req_t          req,
	output logic [CHAR_W-1:0] rdata
);

	logic [CHAR_W-1:0] mem [CELLS];
	logic [CHAR_W-1:0] rdata_q;

	// Synchronous write port and registered read port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

	// The sequencer never reads and writes in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.we && req.re))
		else $error("cell store read and write in one cycle");

	// Every access stays inside the screen.
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(req.we || req.re) |-> (32'(req.addr) < CELLS))
		else $error("cell store address beyond the screen");

endmodule

// File: hdl/ccd_seq.sv
// Command sequencer: splits a request into runs of cells and walks them through the store.
`timescale 1ns / 1ps
module ccd_seq import ccd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd_data,
	output logic              cmd_ready,
	input  logic              out_free,
	output logic              push,
	output result_t           push_data,
	output mem_req_t          mem_req,
	input  logic [CHAR_W-1:0] rdata
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_SETUP = 7'b0000100,
		S_WALK  = 7'b0001000,
		S_READ  = 7'b0010000,
		S_RWAIT = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic              vis_q;
	logic              clr_cmd_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [2:0]        run_idx_q;
	logic [CHAR_W-1:0] rchar_q;
	logic              run_en_q;
	logic              vert_q;
	logic [POS_W-1:0]  px_q;
	logic [POS_W-1:0]  py_q;
	logic [POS_W-1:0]  cnt_q;
	logic [CHAR_W-1:0] rch_q;

	logic                      accept;
	mode_t                     mode_in;
	mode_t                     mode_c;
	logic [2:0]                last_idx;
	logic signed [COORD_W-1:0] x1, y1, x2, y2;
	logic signed [COORD_W-1:0] xlo, ylo, dx, dy;
	logic                      vert_c;
	logic [CHAR_W-1:0]         ch_c;
	logic                      en_c;
	logic                      run_end;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign mode_in   = mode_t'(cmd_data.mode);
	assign mode_c    = mode_t'(cmd_q.mode);

	// Index of the last run of the current command.
	always_comb begin
		unique case (mode_c)
			MODE_HARROW, MODE_VARROW: last_idx = 3'd1;
			MODE_RECT:                last_idx = 3'd7;
			default:                  last_idx = 3'd0;
		endcase
	end

	// Endpoints, direction and character of the current run.
	always_comb begin
		x1     = cmd_q.x_a;
		y1     = cmd_q.y_a;
		x2     = cmd_q.x_a;
		y2     = cmd_q.y_a;
		vert_c = 1'b0;
		ch_c   = CH_SPACE;
		unique case (mode_c)
			MODE_PIXEL: begin
				ch_c = cmd_q.fill_char;
			end
			MODE_HLINE: begin
				x2   = cmd_q.x_b;
				ch_c = CH_DASH;
			end
			MODE_VLINE: begin
				y2     = cmd_q.y_b;
				vert_c = 1'b1;
				ch_c   = CH_BAR;
			end
			MODE_HARROW: begin
				if (run_idx_q == 3'd0) begin
					x2   = cmd_q.x_b;
					ch_c = CH_DASH;
				end else begin
					x1   = cmd_q.x_b;
					x2   = cmd_q.x_b;
					ch_c = (cmd_q.x_a < cmd_q.x_b) ? CH_GT : CH_LT;
				end
			end
			MODE_VARROW: begin
				if (run_idx_q == 3'd0) begin
					y2     = cmd_q.y_b;
					vert_c = 1'b1;
					ch_c   = CH_BAR;
				end else begin
					y1   = cmd_q.y_b;
					y2   = cmd_q.y_b;
					ch_c = (cmd_q.y_a < cmd_q.y_b) ? CH_VEE : CH_CARET;
				end
			end
			MODE_RECT: begin
				// Runs 0 to 3 are the edges, runs 4 to 7 the corners.
				x1     = run_idx_q[0] ? cmd_q.x_b : cmd_q.x_a;
				y1     = run_idx_q[1] ? cmd_q.y_b : cmd_q.y_a;
				x2     = x1;
				y2     = y1;
				ch_c   = CH_PLUS;
				if (!run_idx_q[2]) begin
					if (!run_idx_q[1]) begin
						x1   = cmd_q.x_a;
						x2   = cmd_q.x_b;
						y1   = run_idx_q[0] ? cmd_q.y_b : cmd_q.y_a;
						y2   = y1;
						ch_c = CH_DASH;
					end else begin
						x1     = run_idx_q[0] ? cmd_q.x_b : cmd_q.x_a;
						x2     = x1;
						y1     = cmd_q.y_a;
						y2     = cmd_q.y_b;
						vert_c = 1'b1;
						ch_c   = CH_BAR;
					end
				end
			end
			MODE_READ, MODE_CLEAR: begin
				ch_c = CH_SPACE;
			end
			default: begin
				ch_c = CH_SPACE;
			end
		endcase
	end

	// Start point and length of the run; it draws only with both ends on screen.
	always_comb begin
		en_c = on_scr(x1, y1) && on_scr(x2, y2);
		xlo  = (x1 < x2) ? x1 : x2;
		ylo  = (y1 < y2) ? y1 : y2;
		dx   = (x1 < x2) ? (x2 - x1) : (x1 - x2);
		dy   = (y1 < y2) ? (y2 - y1) : (y1 - y2);
	end

	assign run_end = !run_en_q || (cnt_q == '0);

	// Store access for the current state.
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = clr_addr_q;
				mem_req.wdata = CH_SPACE;
			end
			S_WALK: begin
				mem_req.we    = run_en_q;
				mem_req.addr  = cell_addr(px_q, py_q);
				mem_req.wdata = rch_q;
			end
			S_READ: begin
				mem_req.re   = vis_q;
				mem_req.addr = cell_addr(cmd_q.x_a[POS_W-1:0], cmd_q.y_a[POS_W-1:0]);
			end
			S_IDLE, S_SETUP, S_RWAIT, S_DONE: begin
				mem_req = '0;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	assign push                = (state_q == S_DONE) && out_free;
	assign push_data.cell_char = rchar_q;
	assign push_data.on_screen = vis_q;

	// Control state; reset starts with a clearing pass over the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			clr_cmd_q  <= 1'b0;
			run_idx_q  <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clr_addr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= clr_cmd_q ? S_DONE : S_IDLE;
					end
					clr_addr_q <= clr_addr_q + 1'b1;
				end
				S_IDLE: begin
					if (accept) begin
						run_idx_q  <= '0;
						clr_addr_q <= '0;
						clr_cmd_q  <= 1'b1;
						priority case (mode_in)
							MODE_READ:  state_q <= S_READ;
							MODE_CLEAR: state_q <= S_CLEAR;
							default:    state_q <= S_SETUP;
						endcase
					end
				end
				S_SETUP: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (run_end) begin
						if (run_idx_q == last_idx) begin
							state_q <= S_DONE;
						end else begin
							run_idx_q <= run_idx_q + 1'b1;
							state_q   <= S_SETUP;
						end
					end
				end
				S_READ: begin
					state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request, run and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_data;
			vis_q   <= on_scr(cmd_data.x_a, cmd_data.y_a);
			rchar_q <= '0;
		end
		if (state_q == S_SETUP) begin
			run_en_q <= en_c;
			vert_q   <= vert_c;
			px_q     <= xlo[POS_W-1:0];
			py_q     <= ylo[POS_W-1:0];
			cnt_q    <= vert_c ? dy[POS_W-1:0] : dx[POS_W-1:0];
			rch_q    <= ch_c;
		end
		if (state_q == S_WALK && !run_end) begin
			cnt_q <= cnt_q - 1'b1;
			if (vert_q) begin
				py_q <= py_q + 1'b1;
			end else begin
				px_q <= px_q + 1'b1;
			end
		end
		if (state_q == S_RWAIT) begin
			rchar_q <= vis_q ? rdata : '0;
		end
	end

	// A walk only writes cells that lie on the screen.
	a_walk_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && run_en_q) |->
			(32'(px_q) < COLUMNS && 32'(py_q) < ROWS))
		else $error("walk writes outside the screen");

	// A run that is not finished keeps walking.
	a_walk_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && !run_end) |=> (state_q == S_WALK))
		else $error("run left before its last cell");

	// After a result leaves, the sequencer is idle and ready for the next request.
	a_push_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (state_q == S_IDLE && cmd_ready))
		else $error("sequencer not idle after result");

endmodule
